// ===== rtl/ttwr_pkg.sv =====
// shared constants, types and codes for the tile window refill block
`default_nettype none
package ttwr_pkg;

  localparam int WINDOW_TILES = 4;
  localparam int WT_BITS      = $clog2(WINDOW_TILES);
  localparam int SLOT_COUNT   = WINDOW_TILES * WINDOW_TILES;
  localparam int SLOT_BITS    = 2 * WT_BITS;
  localparam int MAX_LOADS    = 16;
  localparam int LOAD_LIMIT   = (SLOT_COUNT < MAX_LOADS) ? SLOT_COUNT : MAX_LOADS;
  localparam int COORD_W      = 16;
  localparam int SLOT_IDX_W   = 4;
  localparam int BUDGET_W     = 5;
  localparam int SCAN_OFFSET  = WINDOW_TILES / 2 - 1;
  localparam int OUT_DATA_W   = 40;

  // configuration register indexes
  localparam logic CFG_WINDOW_ENABLED = 1'b0;
  localparam logic CFG_REFILL_BUDGET  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  typedef struct packed {
    logic start;    // latch camera tile, set up budget and counters
    logic scan_en;  // evaluate current window position
    logic flush;    // move pending load to output as final load
  } cmd_t;

  typedef struct packed {
    logic enabled;
    logic miss;
    logic pend_valid;
    logic out_free;
    logic budget_hit;
    logic at_end;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/ttwr_ctrl.sv =====
// controller state machine for the tile window refill block
`default_nettype none
module ttwr_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  ttwr_pkg::status_t status_i,
  output ttwr_pkg::cmd_t    cmd_o
);
  import ttwr_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (status_i.enabled) state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.budget_hit) begin
          state_d = ST_FLUSH;
        end else if (!(status_i.miss && status_i.pend_valid && !status_i.out_free)) begin
          cmd_o.scan_en = 1'b1;
          if (status_i.at_end) state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

// ===== rtl/ttwr_dp.sv =====
// datapath: config registers, tag store, scan counters, pending and output registers
`default_nettype none
module ttwr_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  input  wire                                   cfg_index_i,
  input  wire  [ttwr_pkg::BUDGET_W-1:0]         cfg_data_i,
  input  wire  [ttwr_pkg::COORD_W-1:0]          cam_col_i,
  input  wire  [ttwr_pkg::COORD_W-1:0]          cam_row_i,
  input  ttwr_pkg::cmd_t                        cmd_i,
  output ttwr_pkg::status_t                     status_o,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic [ttwr_pkg::COORD_W-1:0]          out_col_o,
  output logic [ttwr_pkg::COORD_W-1:0]          out_row_o,
  output logic [ttwr_pkg::SLOT_IDX_W-1:0]       out_slot_o,
  output logic                                  out_last_o
);
  import ttwr_pkg::*;

  logic                  enabled_q;
  logic [BUDGET_W-1:0]   refill_q;
  logic                  first_q;

  logic [COORD_W-1:0]    cam_col_q, cam_row_q;
  logic [SLOT_BITS-1:0]  pos_q;
  logic [BUDGET_W-1:0]   done_q, budget_q;

  logic                  tag_valid_q [SLOT_COUNT];
  logic [COORD_W-1:0]    tag_col_q   [SLOT_COUNT];
  logic [COORD_W-1:0]    tag_row_q   [SLOT_COUNT];

  logic                  pend_valid_q;
  logic [COORD_W-1:0]    pend_col_q, pend_row_q;
  logic [SLOT_IDX_W-1:0] pend_slot_q;

  logic                  out_valid_q;

  logic [WT_BITS-1:0]    pos_i, pos_j;
  logic [COORD_W-1:0]    cur_col, cur_row;
  logic [SLOT_BITS-1:0]  cur_slot;
  logic                  miss, out_free, push_pend;
  logic [BUDGET_W-1:0]   refill_clamp;

  assign pos_i    = pos_q[SLOT_BITS-1:WT_BITS];
  assign pos_j    = pos_q[WT_BITS-1:0];
  assign cur_row  = cam_row_q + COORD_W'(pos_i) - COORD_W'(SCAN_OFFSET);
  assign cur_col  = cam_col_q + COORD_W'(pos_j) - COORD_W'(SCAN_OFFSET);
  // non-negative modulo of a power-of-two window is the low bits
  assign cur_slot = {cur_row[WT_BITS-1:0], cur_col[WT_BITS-1:0]};
  assign miss     = !(tag_valid_q[cur_slot] && tag_col_q[cur_slot] == cur_col
                      && tag_row_q[cur_slot] == cur_row);
  assign out_free = !out_valid_q || out_ready_i;
  assign push_pend = (cmd_i.scan_en && miss && pend_valid_q) || cmd_i.flush;
  assign refill_clamp = (refill_q > BUDGET_W'(LOAD_LIMIT)) ? BUDGET_W'(LOAD_LIMIT) : refill_q;

  assign status_o.enabled    = enabled_q;
  assign status_o.miss       = miss;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;
  assign status_o.budget_hit = (done_q == budget_q);
  assign status_o.at_end     = (pos_q == SLOT_BITS'(SLOT_COUNT - 1));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b0;
      refill_q     <= BUDGET_W'(2);
      first_q      <= 1'b1;
      pos_q        <= '0;
      done_q       <= '0;
      budget_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) tag_valid_q[k] <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WINDOW_ENABLED: enabled_q <= cfg_data_i[0];
          CFG_REFILL_BUDGET:  refill_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start && enabled_q) begin
        pos_q        <= '0;
        done_q       <= '0;
        budget_q     <= first_q ? BUDGET_W'(LOAD_LIMIT) : refill_clamp;
        first_q      <= 1'b0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.scan_en) begin
        pos_q <= pos_q + SLOT_BITS'(1);
        if (miss) begin
          tag_valid_q[cur_slot] <= 1'b1;
          pend_valid_q          <= 1'b1;
          done_q                <= done_q + BUDGET_W'(1);
        end
      end
      if (cmd_i.flush) pend_valid_q <= 1'b0;
      if (push_pend) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cam_col_q <= cam_col_i;
      cam_row_q <= cam_row_i;
    end
    if (cmd_i.scan_en && miss) begin
      tag_col_q[cur_slot] <= cur_col;
      tag_row_q[cur_slot] <= cur_row;
      pend_col_q          <= cur_col;
      pend_row_q          <= cur_row;
      pend_slot_q         <= SLOT_IDX_W'(cur_slot);
    end
    if (push_pend) begin
      out_col_o  <= pend_col_q;
      out_row_o  <= pend_row_q;
      out_slot_o <= pend_slot_q;
      out_last_o <= cmd_i.flush;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/toroidal_tile_window_refill.sv =====
// top level of the toroidal tile window refill block
// usage:
//   s_axis carries one item per frame: the camera tile column and row
//   m_axis carries one load request per stale window slot, within the budget, in scan order,
//   row by row around the camera; tlast marks the final load of the frame
//   cfg writes window_enabled (index 0) and refill_budget (index 1); the user must
//   write only while the block is idle (not enforced); cfg_ready_o is always high
// timing:
//   an item is accepted only in idle; the scan then visits one window slot
//   per cycle unless paused, all 16 slots in scan order, and a flush state
//   follows that hands any pending load to the output as the final load;
//   a spent budget ends the scan early and moves on to the flush state
//   a disabled item is taken in idle and gives no loads
// stalls:
//   one load waits in a pending register until the next miss or the end of
//   the scan decides its tlast; the scan pauses when a new miss finds both
//   the pending and the output register full
// reset:
//   all tags invalid, first frame pending (full window budget), block
//   disabled, refill_budget 2
`default_nettype none
module toroidal_tile_window_refill (
  input  wire         clk_i,
  input  wire         rst_ni,
  // config write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [4:0]  cfg_data_i,
  // input items
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // camera_tile_col[15:0], camera_tile_row[31:16]
  // load requests
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // load_col[15:0], load_row[31:16],
                                        // slot_index[35:32], zero[39:36]
  output logic        m_axis_tlast_o    // last_load
);
  import ttwr_pkg::*;

  cmd_t                  cmd;
  status_t               status;
  logic [COORD_W-1:0]    out_col, out_row;
  logic [SLOT_IDX_W-1:0] out_slot;

  assign cfg_ready_o = 1'b1;

  ttwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttwr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cam_col_i   (s_axis_tdata_i[15:0]),
    .cam_row_i   (s_axis_tdata_i[31:16]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_col_o   (out_col),
    .out_row_o   (out_row),
    .out_slot_o  (out_slot),
    .out_last_o  (m_axis_tlast_o)
  );

  // pack fields lowest first, pad to whole bytes
  assign m_axis_tdata_o = {
    (OUT_DATA_W - 2 * COORD_W - SLOT_IDX_W)'(0), out_slot, out_row, out_col
  };

endmodule
`default_nettype wire
